// ===== src/u64au_pkg.sv =====
// Shared types and constants for the unsigned arithmetic unit.
// No dependencies.
`default_nettype none

package u64au_pkg;

    localparam int DATA_W = 64;
    localparam int OP_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_INC = 3'd5,
        OP_DEC = 3'd6,
        OP_CMP = 3'd7
    } t_op;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic iterate;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/unsigned_64bit_arith_unit.sv =====
// Unsigned arithmetic unit. Multiply, divide and modulo use the radix-2
// shift-add / restoring-divide step that handles one bit per cycle; all
// other operations, and division by zero, bypass that step.
// One item is in flight at a time; o_ready returns the cycle after the
// result is taken, so no new item is accepted until the last result has
// been taken. Operands are cut to WORD_WIDTH bits and the result is
// zero-extended to 64 bits. Depends on u64au_pkg, u64au_ctrl and u64au_dp.
`default_nettype none

module unsigned_64bit_arith_unit
    import u64au_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [DATA_W-1:0] i_operand_a,
    input  wire logic [DATA_W-1:0] i_operand_b,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_result,
    output logic                   o_div_by_zero,
    output logic                   o_a_less,
    output logic                   o_a_equal,
    output logic                   o_a_greater
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    u64au_ctrl #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    u64au_dp #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_op          (i_op),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_result      (o_result),
        .o_div_by_zero (o_div_by_zero),
        .o_a_less      (o_a_less),
        .o_a_equal     (o_a_equal),
        .o_a_greater   (o_a_greater)
    );

endmodule

`default_nettype wire

// ===== src/u64au_ctrl.sv =====
// Controller state machine: sequences load, iteration and result hand-off.
// Depends on u64au_pkg.
`default_nettype none

module u64au_ctrl
    import u64au_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  wire logic       i_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam int CNT_W = $clog2(WORD_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ITER,
        S_FIN,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ready;
    logic             r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ready <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid && r_ready) begin
                        r_ready <= 1'b0;
                        r_cnt   <= CNT_W'(WORD_WIDTH - 1);
                        r_state <= i_status.iterate ? S_ITER : S_FIN;
                    end
                end
                S_ITER: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_ready       = r_ready;
    assign o_valid       = r_valid;
    assign o_cmd.load    = i_valid && r_ready;
    assign o_cmd.step    = (r_state == S_ITER);
    assign o_cmd.finish  = (r_state == S_FIN);

endmodule

`default_nettype wire

// ===== src/u64au_dp.sv =====
// Datapath: operand registers, shift-add multiply / restoring divide step,
// and the result register. Depends on u64au_pkg.
`default_nettype none

module u64au_dp
    import u64au_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  wire logic              i_clk,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [DATA_W-1:0] i_operand_a,
    input  wire logic [DATA_W-1:0] i_operand_b,
    output logic [DATA_W-1:0]      o_result,
    output logic                   o_div_by_zero,
    output logic                   o_a_less,
    output logic                   o_a_equal,
    output logic                   o_a_greater
);

    localparam int W = WORD_WIDTH;

    t_op          w_op_in;
    logic [W-1:0] w_a_in;
    logic [W-1:0] w_b_in;

    t_op          r_op;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_q;

    logic [W-1:0] n_a;
    logic [W-1:0] n_acc;
    logic [W-1:0] n_q;

    logic [W:0]   w_trial;
    logic [W:0]   w_diff;

    logic [W-1:0] n_res;
    logic         n_dz;
    logic         n_lt;
    logic         n_eq;
    logic         n_gt;

    logic [W-1:0] r_res;
    logic         r_dz;
    logic         r_lt;
    logic         r_eq;
    logic         r_gt;

    assign w_op_in = t_op'(i_op);
    assign w_a_in  = i_operand_a[W-1:0];
    assign w_b_in  = i_operand_b[W-1:0];

    assign o_status.iterate = (w_op_in == OP_MUL) ||
                              (((w_op_in == OP_DIV) || (w_op_in == OP_MOD)) &&
                               (w_b_in != '0));

    // one radix-2 step: multiply shifts multiplicand left / multiplier right,
    // divide shifts dividend bits into the partial remainder
    assign w_trial = {r_acc, r_q[W-1]};
    assign w_diff  = w_trial - {1'b0, r_b};

    always_comb begin
        if (r_op == OP_MUL) begin
            n_acc = r_q[0] ? (r_acc + r_a) : r_acc;
            n_a   = {r_a[W-2:0], 1'b0};
            n_q   = {1'b0, r_q[W-1:1]};
        end else begin
            n_a = r_a;
            if (!w_diff[W]) begin
                n_acc = w_diff[W-1:0];
                n_q   = {r_q[W-2:0], 1'b1};
            end else begin
                n_acc = w_trial[W-1:0];
                n_q   = {r_q[W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_res = '0;
        n_dz  = 1'b0;
        n_lt  = 1'b0;
        n_eq  = 1'b0;
        n_gt  = 1'b0;
        case (r_op)
            OP_ADD: n_res = r_a + r_b;
            OP_SUB: n_res = r_a - r_b;
            OP_MUL: n_res = r_acc;
            OP_DIV: begin
                if (r_b == '0) begin
                    n_dz = 1'b1;
                end else begin
                    n_res = r_q;
                end
            end
            OP_MOD: begin
                if (r_b == '0) begin
                    n_dz = 1'b1;
                end else begin
                    n_res = r_acc;
                end
            end
            OP_INC: n_res = r_a + W'(1);
            OP_DEC: n_res = r_a - W'(1);
            OP_CMP: begin
                n_lt = (r_a < r_b);
                n_eq = (r_a == r_b);
                n_gt = (r_a > r_b);
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= w_op_in;
            r_a   <= w_a_in;
            r_b   <= w_b_in;
            r_acc <= '0;
            r_q   <= (w_op_in == OP_MUL) ? w_b_in : w_a_in;
        end else if (i_cmd.step) begin
            r_a   <= n_a;
            r_acc <= n_acc;
            r_q   <= n_q;
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
            r_dz  <= n_dz;
            r_lt  <= n_lt;
            r_eq  <= n_eq;
            r_gt  <= n_gt;
        end
    end

    assign o_result      = DATA_W'(r_res);
    assign o_div_by_zero = r_dz;
    assign o_a_less      = r_lt;
    assign o_a_equal     = r_eq;
    assign o_a_greater   = r_gt;

endmodule

`default_nettype wire

// ===== src/u64au_checker.sv =====
// Port-level checks for the arithmetic unit, bound to the top level.
// Depends on u64au_pkg and unsigned_64bit_arith_unit.
`default_nettype none

module u64au_checker
    import u64au_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [DATA_W-1:0] o_result,
    input wire logic              o_div_by_zero,
    input wire logic              o_a_less,
    input wire logic              o_a_equal,
    input wire logic              o_a_greater
);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after an item was accepted");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result)))
        else $error("stalled result dropped or changed");

    a_cmp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_a_less, o_a_equal, o_a_greater}) <= 1))
        else $error("more than one compare flag set");

    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_by_zero) |->
            ((o_result == '0) && !o_a_less && !o_a_equal && !o_a_greater))
        else $error("divide-by-zero item carries a result");

endmodule

bind unsigned_64bit_arith_unit u64au_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result      (o_result),
    .o_div_by_zero (o_div_by_zero),
    .o_a_less      (o_a_less),
    .o_a_equal     (o_a_equal),
    .o_a_greater   (o_a_greater)
);

`default_nettype wire
